// File: sv/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, skipped while reset is low
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// implication checked on every rising edge, skipped while reset is low
`define ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication, skipped while reset is low
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: sv/mfv_pkg.sv
package mfv_pkg;

    // frame delimiters and markers
    localparam logic [7:0] START_BYTE = 8'h68;
    localparam logic [7:0] END_BYTE   = 8'h16;
    localparam logic [7:0] WILDCARD   = 8'hAA;

    // header plus checksum and end byte around the data field
    localparam logic [8:0] FRAME_OVERHEAD = 9'd12;
    // byte count reached after the length byte
    localparam logic [8:0] HEADER_BYTES   = 9'd10;
    // byte count reached after the last address byte
    localparam logic [8:0] ADDR_DONE      = 9'd7;

    localparam logic [8:0] MAX_LEN_RESET  = 9'd267;

    typedef enum logic [1:0] {
        CFG_EXPECT_REQUEST = 2'd0,
        CFG_CHECK_ADDRESS  = 2'd1,
        CFG_LOCAL_ADDRESS  = 2'd2,
        CFG_MAX_FRAME_LEN  = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TOO_LONG    = 3'd1,
        ST_WRONG_DIR   = 3'd2,
        ST_BAD_END     = 3'd3,
        ST_BAD_SUM     = 3'd4,
        ST_ADDR_MISS   = 3'd5,
        ST_NO_START2   = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_ADDR   = 3'd1,
        PH_START2 = 3'd2,
        PH_CTRL   = 3'd3,
        PH_LEN    = 3'd4,
        PH_DATA   = 3'd5,
        PH_SUM    = 3'd6,
        PH_END    = 3'd7
    } t_phase;

    typedef struct packed {
        logic        expect_request;
        logic        check_address;
        logic [47:0] local_address;
        logic [8:0]  max_frame_len;
    } t_cfg;

    typedef struct packed {
        t_status    status;
        logic [8:0] frame_len;
        logic [7:0] ctrl_code;
    } t_result;

endpackage

// File: sv/mfv_cfg_regs.sv
module mfv_cfg_regs
    import mfv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    // register write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expect_request <= 1'b0;
            r_cfg.check_address  <= 1'b1;
            r_cfg.local_address  <= 48'd0;
            r_cfg.max_frame_len  <= MAX_LEN_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_EXPECT_REQUEST: r_cfg.expect_request <= i_cfg_data[0];
                CFG_CHECK_ADDRESS:  r_cfg.check_address  <= i_cfg_data[0];
                CFG_LOCAL_ADDRESS:  r_cfg.local_address  <= i_cfg_data;
                CFG_MAX_FRAME_LEN:  r_cfg.max_frame_len  <= i_cfg_data[8:0];
                default:            r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: sv/mfv_frame_fsm.sv
`include "assert_macros.svh"

module mfv_frame_fsm
    import mfv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  t_cfg       i_cfg,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_phase     r_phase,      n_phase;
    logic [8:0] r_byte_count, n_byte_count;
    logic [7:0] r_sum,        n_sum;
    logic [7:0] r_data_len,   n_data_len;
    logic [7:0] r_ctrl,       n_ctrl;
    logic       r_addr_miss,  n_addr_miss;

    logic [8:0] w_count_inc;
    logic [2:0] w_addr_idx;
    logic [7:0] w_local_byte;
    logic [8:0] w_len_flen;
    logic [8:0] w_end_flen;
    logic [8:0] w_data_last;

    // frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_byte_count <= 9'd0;
            r_sum        <= 8'd0;
            r_data_len   <= 8'd0;
            r_ctrl       <= 8'd0;
            r_addr_miss  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_byte_count <= n_byte_count;
            r_sum        <= n_sum;
            r_data_len   <= n_data_len;
            r_ctrl       <= n_ctrl;
            r_addr_miss  <= n_addr_miss;
        end
    end

    // shared arithmetic
    assign w_count_inc = r_byte_count + 9'd1;
    assign w_addr_idx  = r_byte_count[2:0] - 3'd1;
    assign w_len_flen  = {1'b0, i_byte} + FRAME_OVERHEAD;
    assign w_end_flen  = {1'b0, r_data_len} + FRAME_OVERHEAD;
    assign w_data_last = HEADER_BYTES + {1'b0, r_data_len};

    // local address byte for the current address position
    always_comb begin
        case (w_addr_idx)
            3'd0:    w_local_byte = i_cfg.local_address[7:0];
            3'd1:    w_local_byte = i_cfg.local_address[15:8];
            3'd2:    w_local_byte = i_cfg.local_address[23:16];
            3'd3:    w_local_byte = i_cfg.local_address[31:24];
            3'd4:    w_local_byte = i_cfg.local_address[39:32];
            default: w_local_byte = i_cfg.local_address[47:40];
        endcase
    end

    // next state and result
    always_comb begin
        n_phase      = r_phase;
        n_byte_count = r_byte_count;
        n_sum        = r_sum;
        n_data_len   = r_data_len;
        n_ctrl       = r_ctrl;
        n_addr_miss  = r_addr_miss;
        o_res_valid  = 1'b0;
        o_res        = '{status: ST_OK, frame_len: 9'd0, ctrl_code: 8'd0};
        if (i_step) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_byte == START_BYTE) begin
                        n_sum        = START_BYTE;
                        n_byte_count = 9'd1;
                        n_addr_miss  = 1'b0;
                        n_ctrl       = 8'd0;
                        n_data_len   = 8'd0;
                        n_phase      = PH_ADDR;
                    end
                end
                PH_ADDR: begin
                    if (w_local_byte != WILDCARD && i_byte != w_local_byte) begin
                        n_addr_miss = 1'b1;
                    end
                    n_sum        = r_sum + i_byte;
                    n_byte_count = w_count_inc;
                    if (w_count_inc >= ADDR_DONE) begin
                        n_phase = PH_START2;
                    end
                end
                PH_START2: begin
                    if (i_byte != START_BYTE) begin
                        o_res_valid = 1'b1;
                        o_res       = '{status: ST_NO_START2, frame_len: 9'd0,
                                        ctrl_code: 8'd0};
                        n_phase     = PH_HUNT;
                    end else begin
                        n_sum        = r_sum + i_byte;
                        n_byte_count = ADDR_DONE + 9'd1;
                        n_phase      = PH_CTRL;
                    end
                end
                PH_CTRL: begin
                    n_ctrl       = i_byte;
                    n_sum        = r_sum + i_byte;
                    n_byte_count = ADDR_DONE + 9'd2;
                    n_phase      = PH_LEN;
                end
                PH_LEN: begin
                    n_data_len   = i_byte;
                    n_sum        = r_sum + i_byte;
                    n_byte_count = HEADER_BYTES;
                    // length check first, then direction bit
                    if (w_len_flen > i_cfg.max_frame_len) begin
                        o_res_valid = 1'b1;
                        o_res       = '{status: ST_TOO_LONG, frame_len: w_len_flen,
                                        ctrl_code: r_ctrl};
                        n_phase     = PH_HUNT;
                    end else if (r_ctrl[7] == i_cfg.expect_request) begin
                        o_res_valid = 1'b1;
                        o_res       = '{status: ST_WRONG_DIR, frame_len: w_len_flen,
                                        ctrl_code: r_ctrl};
                        n_phase     = PH_HUNT;
                    end else begin
                        n_phase = (i_byte != 8'd0) ? PH_DATA : PH_SUM;
                    end
                end
                PH_DATA: begin
                    n_sum        = r_sum + i_byte;
                    n_byte_count = w_count_inc;
                    if (w_count_inc >= w_data_last) begin
                        n_phase = PH_SUM;
                    end
                end
                PH_SUM: begin
                    // zero sum after this means the checksum matched
                    n_sum        = r_sum - i_byte;
                    n_byte_count = w_count_inc;
                    n_phase      = PH_END;
                end
                PH_END: begin
                    n_byte_count = w_count_inc;
                    o_res_valid  = 1'b1;
                    o_res.frame_len = w_end_flen;
                    o_res.ctrl_code = r_ctrl;
                    if (i_byte != END_BYTE) begin
                        o_res.status = ST_BAD_END;
                    end else if (r_sum != 8'd0) begin
                        o_res.status = ST_BAD_SUM;
                    end else if (i_cfg.check_address && r_addr_miss) begin
                        o_res.status = ST_ADDR_MISS;
                    end else begin
                        o_res.status = ST_OK;
                    end
                    n_phase = PH_HUNT;
                end
                default: n_phase = PH_HUNT;
            endcase
        end
    end

    // address phase only ever sees positions one to six
    `ASSERT_IMPLY(a_addr_pos, r_phase == PH_ADDR,
        r_byte_count != 9'd0 && r_byte_count <= 9'd6, "address position out of range")

endmodule

// File: sv/meter_frame_validator.sv
// Streaming validator for meter link frames (start byte, six address bytes,
// second start byte, control, length, data, checksum, end byte).
// Input channel: i_in_valid / o_in_stall with i_rx_byte, one line byte per
// transfer. Output channel: o_out_valid / i_out_stall with o_status,
// o_frame_len and o_ctrl_code, one status per frame or at the first fatal error.
// Configuration: write i_cfg_data to register i_cfg_index when i_cfg_wr_en is
// high; 0 expect_request, 1 check_address, 2 local_address, 3 max_frame_len.
// Write configuration only while no frame is in flight.
// Throughput: one byte per cycle while no result is held by i_out_stall; the frame
// state update for a byte is a compare and an 8-bit add between the input register
// and the result register. Path: a transferred byte sits in the input register,
// is processed by the frame state machine, and its status is registered in the
// result register, which drives o_out_valid and the status outputs.
// Stall: while i_out_stall holds a result, the byte waiting in the input
// register is held and o_in_stall rises; bytes that give no result still
// wait behind the held result. Nothing is dropped.
// Reset (synchronous, active low): clears both stages and returns to hunting
// for a start byte; registers return to their defaults.
`include "assert_macros.svh"

module meter_frame_validator
    import mfv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [8:0]  o_frame_len,
    output logic [7:0]  o_ctrl_code
);

    t_cfg       w_cfg;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    logic       w_step;
    logic       w_in_xfer;
    logic       w_res_valid;
    t_result    w_res;

    mfv_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // byte moves on when the result register is free or being emptied
    assign w_step     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_step;
    assign w_in_xfer  = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in_byte <= i_rx_byte;
        end
    end

    mfv_frame_fsm u_frame_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_byte      (r_in_byte),
        .i_cfg       (w_cfg),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out.status;
    assign o_frame_len = r_out.frame_len;
    assign o_ctrl_code = r_out.ctrl_code;

    // upstream is only held back by a full input register
    `ASSERT_IMPLY(a_stall_needs_byte, o_in_stall, r_in_valid, "stall with empty input register")
    // a held result is never lost
    `ASSERT_NEXT(a_result_kept, r_out_valid && i_out_stall, r_out_valid,
        "stalled result dropped")
    // a new result only lands when the register is free or draining
    `ASSERT_IMPLY(a_no_overwrite, w_res_valid, !r_out_valid || !i_out_stall,
        "result overwrote a held result")

endmodule

// File: tb/tb_top.sv
module tb_top;
    import mfv_pkg::*;

    // kinds of damage a generated frame may carry
    typedef enum int {
        FAULT_NONE,
        FAULT_START2,
        FAULT_DIR,
        FAULT_END,
        FAULT_SUM,
        FAULT_ADDR
    } frame_fault_e;

    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 4;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [47:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic [7:0]  rx_byte = '0;
    logic        out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [2:0]  o_status;
    logic [8:0]  o_frame_len;
    logic [7:0]  o_ctrl_code;

    // bytes waiting for the driver and statuses waiting for the dut
    logic [7:0] rx_pending[$];
    t_result    status_expected[$];

    // register copy and frame tracking state of the predictor
    t_cfg       model_cfg = '{1'b0, 1'b1, 48'h0, MAX_LEN_RESET};
    t_phase     trk_phase = PH_HUNT;
    logic [8:0] trk_count = '0;
    logic [7:0] trk_sum = '0;
    logic [7:0] trk_dlen = '0;
    logic [7:0] trk_ctrl = '0;
    logic       trk_miss = 1'b0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int queued_bytes = 0;
    int bytes_taken = 0;
    int results_checked = 0;
    int settings_run = 0;
    int errors = 0;
    int quiet_cycles = 0;
    int status_seen[7];

    meter_frame_validator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_rx_byte   (rx_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_status    (o_status),
        .o_frame_len (o_frame_len),
        .o_ctrl_code (o_ctrl_code)
    );

    always #5 clk = ~clk;

    // queue one status and go back to hunting
    task automatic post_status(input t_status st, input logic [8:0] flen,
                               input logic [7:0] ctrl);
        t_result r;
        r.status    = st;
        r.frame_len = flen;
        r.ctrl_code = ctrl;
        status_expected.push_back(r);
        trk_phase = PH_HUNT;
    endtask

    // frame tracker: advance by one transferred byte
    task automatic track_byte(input logic [7:0] b);
        logic [8:0] pos;
        logic [2:0] idx;
        logic [7:0] lb;
        logic [8:0] flen;
        t_status    st;
        case (trk_phase)
            PH_HUNT: begin
                if (b == START_BYTE) begin
                    trk_sum   = START_BYTE;
                    trk_count = 9'd1;
                    trk_miss  = 1'b0;
                    trk_ctrl  = '0;
                    trk_dlen  = '0;
                    trk_phase = PH_ADDR;
                end
            end
            PH_ADDR: begin
                pos = trk_count - 9'd1;
                idx = (pos[2:0] > 3'd5) ? 3'd5 : pos[2:0];
                lb  = model_cfg.local_address[8*idx +: 8];
                if (lb != WILDCARD && b != lb) trk_miss = 1'b1;
                trk_sum   += b;
                trk_count += 9'd1;
                if (trk_count >= ADDR_DONE) trk_phase = PH_START2;
            end
            PH_START2: begin
                if (b != START_BYTE) begin
                    post_status(ST_NO_START2, '0, '0);
                end else begin
                    trk_sum   += b;
                    trk_count = 9'd8;
                    trk_phase = PH_CTRL;
                end
            end
            PH_CTRL: begin
                trk_ctrl  = b;
                trk_sum   += b;
                trk_count = 9'd9;
                trk_phase = PH_LEN;
            end
            PH_LEN: begin
                trk_dlen  = b;
                trk_sum   += b;
                trk_count = HEADER_BYTES;
                flen = {1'b0, b} + FRAME_OVERHEAD;
                // length first, then the direction bit (bit 7 of control)
                if (flen > model_cfg.max_frame_len) begin
                    post_status(ST_TOO_LONG, flen, trk_ctrl);
                end else if (model_cfg.expect_request ? trk_ctrl[7] : !trk_ctrl[7]) begin
                    post_status(ST_WRONG_DIR, flen, trk_ctrl);
                end else begin
                    trk_phase = (trk_dlen != 0) ? PH_DATA : PH_SUM;
                end
            end
            PH_DATA: begin
                trk_sum   += b;
                trk_count += 9'd1;
                if (trk_count >= HEADER_BYTES + {1'b0, trk_dlen}) trk_phase = PH_SUM;
            end
            PH_SUM: begin
                trk_sum   -= b;
                trk_count += 9'd1;
                trk_phase = PH_END;
            end
            default: begin
                trk_count += 9'd1;
                flen = {1'b0, trk_dlen} + FRAME_OVERHEAD;
                if (b != END_BYTE) st = ST_BAD_END;
                else if (trk_sum != 0) st = ST_BAD_SUM;
                else if (model_cfg.check_address && trk_miss) st = ST_ADDR_MISS;
                else st = ST_OK;
                post_status(st, flen, trk_ctrl);
            end
        endcase
    endtask

    // input driver: one byte per transfer, random idle cycles
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                track_byte(rx_byte);
                bytes_taken++;
            end
            if (!in_valid || !o_in_stall) begin
                if (rx_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    rx_byte  <= rx_pending.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: random stall, compare each transfer with the oldest status
    always @(posedge clk) begin
        t_result want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            if (o_out_valid && !out_stall) begin
                if (status_expected.size() == 0) begin
                    $display("%0t: unexpected result, expected none, %s %0d len %0d ctrl %h",
                             $time, "got status", o_status, o_frame_len, o_ctrl_code);
                    errors++;
                end else begin
                    want = status_expected.pop_front();
                    results_checked++;
                    status_seen[o_status]++;
                    if (o_status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, o_status);
                        errors++;
                    end
                    if (o_frame_len !== want.frame_len) begin
                        $display("%0t: frame_len mismatch, expected %0d, got %0d",
                                 $time, want.frame_len, o_frame_len);
                        errors++;
                    end
                    if (o_ctrl_code !== want.ctrl_code) begin
                        $display("%0t: ctrl_code mismatch, expected %h, got %h",
                                 $time, want.ctrl_code, o_ctrl_code);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transfer or register write
    always @(posedge clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: watchdog, no transfer for %0d cycles", $time, quiet_cycles);
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        rx_pending.push_back(b);
        queued_bytes++;
    endtask

    // wait until every byte is taken and every status has come out
    task automatic wait_drained();
        while (rx_pending.size() != 0 || in_valid || status_expected.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // register write, only called while the dut is idle
    task automatic write_reg(input t_cfg_idx idx, input logic [47:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_EXPECT_REQUEST: model_cfg.expect_request = val[0];
            CFG_CHECK_ADDRESS:  model_cfg.check_address  = val[0];
            CFG_LOCAL_ADDRESS:  model_cfg.local_address  = val;
            default:            model_cfg.max_frame_len  = val[8:0];
        endcase
    endtask

    task automatic write_all(input logic req, input logic chk, input logic [47:0] addr,
                             input logic [8:0] max_len);
        write_reg(CFG_EXPECT_REQUEST, {47'h0, req});
        write_reg(CFG_CHECK_ADDRESS, {47'h0, chk});
        write_reg(CFG_LOCAL_ADDRESS, addr);
        write_reg(CFG_MAX_FRAME_LEN, {39'h0, max_len});
    endtask

    // drain, then push filler until the tracker is back to hunting
    task automatic finish_setting();
        wait_drained();
        while (trk_phase != PH_HUNT) begin
            push_byte(8'h00);
            wait_drained();
        end
        settings_run++;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0:       begin send_idle_pct = 26; recv_idle_pct = 72; end
            1:       begin send_idle_pct = 72; recv_idle_pct = 26; end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        endcase
    endtask

    // address with some wildcard bytes
    function automatic logic [47:0] mixed_address();
        logic [47:0] a;
        for (int k = 0; k < 6; k++)
            a[8*k +: 8] = ($urandom_range(0, 3) == 0) ? WILDCARD : 8'($urandom);
        return a;
    endfunction

    // build one frame against the current registers, damaged as asked
    task automatic queue_frame(input frame_fault_e fault, input int dlen);
        logic [7:0] b;
        logic [7:0] lb;
        logic [7:0] csum;
        logic [7:0] ctrl;
        int         miss_at;
        int         k;
        miss_at = $urandom_range(0, 5);
        csum = START_BYTE;
        push_byte(START_BYTE);
        for (k = 0; k < 6; k++) begin
            lb = model_cfg.local_address[8*k +: 8];
            b  = (lb == WILDCARD) ? 8'($urandom) : lb;
            if (fault == FAULT_ADDR && k == miss_at) b = lb ^ 8'($urandom_range(1, 255));
            csum += b;
            push_byte(b);
        end
        if (fault == FAULT_START2) begin
            b = 8'($urandom);
            if (b == START_BYTE) b = b + 8'd1;
            push_byte(b);
            return;
        end
        push_byte(START_BYTE);
        csum += START_BYTE;
        ctrl = 8'($urandom);
        ctrl[7] = ~model_cfg.expect_request;
        if (fault == FAULT_DIR) ctrl[7] = ~ctrl[7];
        push_byte(ctrl);
        push_byte(8'(dlen));
        csum += ctrl + 8'(dlen);
        // frame is rejected at the length byte, nothing more to send
        if (fault == FAULT_DIR || dlen + 12 > model_cfg.max_frame_len) return;
        for (k = 0; k < dlen; k++) begin
            b = 8'($urandom);
            csum += b;
            push_byte(b);
        end
        if (fault == FAULT_SUM) csum = csum ^ 8'($urandom_range(1, 255));
        push_byte(csum);
        b = END_BYTE;
        if (fault == FAULT_END) begin
            b = 8'($urandom);
            if (b == END_BYTE) b = b + 8'd1;
        end
        push_byte(b);
    endtask

    // mostly well formed frames, some noise and broken headers
    task automatic queue_random(input int n_bytes);
        int target;
        int r;
        int dlen;
        int n;
        frame_fault_e f;
        target = queued_bytes + n_bytes;
        while (queued_bytes < target) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                n = $urandom_range(1, 6);
                repeat (n) push_byte(8'($urandom));
            end else if (r < 12) begin
                push_byte(START_BYTE);
                n = $urandom_range(1, 12);
                repeat (n) push_byte(8'($urandom));
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) dlen = $urandom_range(0, 4);
                else if (r < 90) dlen = $urandom_range(5, 20);
                else if (r < 99) dlen = $urandom_range(21, 60);
                else dlen = $urandom_range(200, 255);
                f = ($urandom_range(0, 99) < 60) ? FAULT_NONE
                                                 : frame_fault_e'($urandom_range(1, 5));
                queue_frame(f, dlen);
            end
            // sender holds off until the dut has caught up
            if ($urandom_range(0, 24) == 0) wait_drained();
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset register values: response direction, address 0, full length
        set_idling(0);
        push_byte(8'h00);
        push_byte(8'hFF);
        queue_frame(FAULT_NONE, 0);
        queue_frame(FAULT_NONE, 255);
        queue_frame(FAULT_START2, 0);
        queue_frame(FAULT_DIR, 3);
        queue_frame(FAULT_END, 1);
        queue_frame(FAULT_SUM, 2);
        queue_frame(FAULT_ADDR, 0);
        queue_random(170);
        finish_setting();

        // request direction, shortest legal limit, wildcard address
        write_all(1'b1, 1'b1, {WILDCARD, 8'h12, WILDCARD, 8'h34, 8'h56, WILDCARD}, 9'd12);
        queue_frame(FAULT_NONE, 0);
        queue_frame(FAULT_NONE, 1);
        queue_frame(FAULT_DIR, 1);
        queue_frame(FAULT_ADDR, 0);
        queue_random(150);
        finish_setting();

        // address check off, all-ones address, full length
        set_idling(1);
        write_all(1'b0, 1'b0, 48'hFFFF_FFFF_FFFF, MAX_LEN_RESET);
        queue_frame(FAULT_ADDR, 2);
        queue_frame(FAULT_NONE, 0);
        queue_random(150);
        finish_setting();

        // limit below the shortest frame rejects everything
        write_all(1'b1, 1'b1, {6{WILDCARD}}, 9'd11);
        queue_frame(FAULT_NONE, 0);
        queue_random(80);
        finish_setting();

        // limit above the longest frame rejects nothing
        set_idling(2);
        write_all(1'b0, 1'b1, 48'($urandom) | (48'($urandom) << 32), 9'd511);
        queue_frame(FAULT_NONE, 255);
        queue_random(150);
        finish_setting();

        // random limit and mixed wildcard address
        write_all(1'($urandom), 1'b1, mixed_address(), 9'(12 + $urandom_range(2, 30)));
        queue_random(200);
        finish_setting();

        repeat (10) @(negedge clk);
        $display("run covered %0d bytes and %0d statuses over %0d register settings",
                 bytes_taken, results_checked, settings_run);
        $display("statuses: ok %0d, long %0d, dir %0d, end %0d, sum %0d, addr %0d, start2 %0d",
                 status_seen[ST_OK], status_seen[ST_TOO_LONG], status_seen[ST_WRONG_DIR],
                 status_seen[ST_BAD_END], status_seen[ST_BAD_SUM],
                 status_seen[ST_ADDR_MISS], status_seen[ST_NO_START2]);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
